// File: design/tcce_pkg.sv
// Shared types and constants for the text console character engine.
package tcce_pkg;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FINISH
  } tcce_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic latch;
    logic exec;
    logic scroll_step;
    logic load_out;
  } tcce_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clear_done;
    logic is_read;
    logic scroll_need;
    logic scroll_done;
  } tcce_status_t;

endpackage

// File: design/tcce_req_if.sv
// Request channel: one console command per beat.
interface tcce_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, cmd, char_code, read_row, read_col, input ready);
  modport sink   (input valid, cmd, char_code, read_row, read_col, output ready);
endinterface

// File: design/tcce_rsp_if.sv
// Response channel: one result per request beat.
interface tcce_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_attr;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic       scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_col, cursor_row, scrolled,
                  output ready);
endinterface

// File: design/tcce_ctrl.sv
// Controller state machine: sequences clearing, commands, scrolling and the result beat.
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  input  tcce_status_t status,
  output tcce_cmd_t    cmd
);

  tcce_state_t state, state_next;
  logic        out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!status.is_read && status.scroll_need) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.scroll_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/tcce_dp.sv
// Datapath: screen store, cursor, attribute register, sweep pointer and result registers.
module tcce_dp
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data,
  input  logic         req_cmd,
  input  logic [7:0]   req_char_code,
  input  logic [4:0]   req_read_row,
  input  logic [6:0]   req_read_col,
  output logic [7:0]   cell_char,
  output logic [7:0]   cell_attr,
  output logic [6:0]   cursor_col,
  output logic [4:0]   cursor_row,
  output logic         scrolled,
  input  tcce_cmd_t    cmd,
  output tcce_status_t status
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CELLS - 1);
  localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(CELLS);
  localparam logic [PTR_W-1:0] PTR_COPY = PTR_W'(CELLS - COLUMNS);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [7:0]        attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PTR_W-1:0]  ptr;
  logic              scroll_flag;

  logic              lt_cmd;
  logic [7:0]        lt_char;
  logic [4:0]        lt_row;
  logic [6:0]        lt_col;

  logic [COL_W:0]    nc;
  logic [ROW_W:0]    nr;
  logic              printable;
  logic              need_scroll;
  logic              in_range;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Next cursor position for a put of the latched byte.
  always_comb begin
    nc        = {1'b0, col};
    nr        = {1'b0, row};
    printable = !lt_char[7] && (lt_char[6:5] != 2'b00);
    if (lt_char == CH_BACKSPACE && col != '0) begin
      nc = {1'b0, col} - (COL_W+1)'(1);
    end else if (lt_char == CH_TAB) begin
      nc = ({1'b0, col} + (COL_W+1)'(8)) & ~((COL_W+1)'(7));
    end else if (lt_char == CH_CR) begin
      nc = '0;
    end else if (lt_char == CH_LF) begin
      nc = '0;
      nr = {1'b0, row} + (ROW_W+1)'(1);
    end else if (printable) begin
      nc = {1'b0, col} + (COL_W+1)'(1);
    end
    if (32'(nc) >= COLUMNS) begin
      nc = '0;
      nr = nr + (ROW_W+1)'(1);
    end
    need_scroll = 32'(nr) >= ROWS;
  end

  assign in_range = (32'(lt_row) < ROWS) && (32'(lt_col) < COLUMNS);
  assign cur_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign rd_addr  = ADDR_W'(lt_row) * ADDR_W'(COLUMNS) + ADDR_W'(lt_col);

  assign status.clear_done  = (ptr == PTR_LAST);
  assign status.is_read     = (lt_cmd == CMD_READ);
  assign status.scroll_need = need_scroll;
  assign status.scroll_done = (ptr == PTR_END);

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = ptr[ADDR_W-1:0];
    end
    if (cmd.exec) begin
      if (lt_cmd == CMD_PUT && printable) begin
        mem_we    = 1'b1;
        mem_waddr = cur_addr;
        mem_wdata = {attr, lt_char};
      end
      if (lt_cmd == CMD_READ && in_range) begin
        mem_re    = 1'b1;
        mem_raddr = rd_addr;
      end
    end
    if (cmd.scroll_step) begin
      // Read one row ahead; write the previously read cell one step behind.
      if (ptr < PTR_COPY) begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(ptr + PTR_W'(COLUMNS));
      end
      if (ptr != '0) begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(ptr - PTR_W'(1));
        mem_wdata = (ptr <= PTR_COPY) ? rdata : {attr, CH_SPACE};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
      col  <= '0;
      row  <= '0;
      ptr  <= '0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (cmd.clear_step || cmd.scroll_step) begin
        ptr <= ptr + PTR_W'(1);
      end
      if (cmd.exec) begin
        ptr <= '0;
        if (lt_cmd == CMD_PUT) begin
          col <= nc[COL_W-1:0];
          row <= need_scroll ? ROW_W'(ROWS - 1) : nr[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lt_cmd  <= req_cmd;
      lt_char <= req_char_code;
      lt_row  <= req_read_row;
      lt_col  <= req_read_col;
    end
    if (cmd.exec) begin
      scroll_flag <= (lt_cmd == CMD_PUT) && need_scroll;
    end
    if (cmd.load_out) begin
      if (lt_cmd == CMD_READ && in_range) begin
        cell_char <= rdata[7:0];
        cell_attr <= rdata[15:8];
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
      cursor_col <= 7'(col);
      cursor_row <= 5'(row);
      scrolled   <= scroll_flag;
    end
  end

endmodule

// File: design/text_console_char_engine_top.sv
// Top level of the text console character engine: controller, datapath and channel wiring.
//
//   Channel    Role      Beat carries
//   request    sink      cmd, char_code, read_row, read_col
//   response   source    cell_char, cell_attr, cursor_col, cursor_row, scrolled
//   cfg        write     text attribute byte (cfg_we, cfg_data)
//
// After reset the store is cleared one cell per cycle, all ROWS*COLUMNS cells (2000 at the
// default size), and no request is taken until that pass ends.
// A read, or a put that does not scroll, passes the accept, execute and finish steps: the
// response beat is loaded in the finish step, and the next request beat is taken after it.
// A put that scrolls adds a pass over the store, one cell read and one written per cycle.
// A waiting response holds the next result in the finish step until the register is free.
module text_console_char_engine_top
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  tcce_req_if.sink    request,
  tcce_rsp_if.source  response
);

  // Command and status bundles between the controller and the datapath.
  tcce_cmd_t    cmd;
  tcce_status_t status;

  // The controller owns the handshakes and the sequencing of each item.
  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the screen store, the cursor and the response payload.
  tcce_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .req_cmd       (request.cmd),
    .req_char_code (request.char_code),
    .req_read_row  (request.read_row),
    .req_read_col  (request.read_col),
    .cell_char     (response.cell_char),
    .cell_attr     (response.cell_attr),
    .cursor_col    (response.cursor_col),
    .cursor_row    (response.cursor_row),
    .scrolled      (response.scrolled),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// File: bench/tcce_console_checker.sv
// Checker for the text console character engine: predicts every response beat and compares it.
module tcce_console_checker
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  tcce_req_if        req,
  tcce_rsp_if        rsp,
  output int         mismatch_count,
  output int         replies_owed
);

  localparam int         CELLS             = ROWS * COLUMNS;
  localparam logic [7:0] CH_LAST_PRINTABLE = 8'h7F;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } console_reply_t;

  logic [15:0]    screen [CELLS];
  int unsigned    cur_col;
  int unsigned    cur_line;
  logic [7:0]     text_attr;
  console_reply_t replies_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one command to the shadow screen and cursor and returns the reply it causes.
  function automatic console_reply_t predict_console_reply(input logic cmd,
                                                           input logic [7:0] code,
                                                           input logic [4:0] row,
                                                           input logic [6:0] col);
    console_reply_t r;
    r = '0;
    if (cmd == CMD_PUT) begin
      if (code == CH_BACKSPACE) begin
        if (cur_col != 0) cur_col--;
      end else if (code == CH_TAB) begin
        cur_col = (cur_col + 8) & ~32'd7;
      end else if (code == CH_CR) begin
        cur_col = 0;
      end else if (code == CH_LF) begin
        cur_col = 0;
        cur_line++;
      end else if (code >= CH_SPACE && code <= CH_LAST_PRINTABLE) begin
        if (cur_line * COLUMNS + cur_col < CELLS)
          screen[cur_line * COLUMNS + cur_col] = {text_attr, code};
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_line++;
      end
      if (cur_line >= ROWS) begin
        // Every row moves up one and the bottom row is blanked with the current attribute.
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {text_attr, CH_SPACE};
        cur_line   = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end else if (row < ROWS && col < COLUMNS) begin
      {r.cell_attr, r.cell_char} = screen[row * COLUMNS + col];
    end
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_line[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    console_reply_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cur_col        = 0;
      cur_line       = 0;
      text_attr      = ATTR_RESET;
      mismatch_count = 0;
      replies_q.delete();
    end else begin
      if (cfg_we) text_attr = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (replies_q.size() == 0) begin
          report_mismatch("response beat with no command outstanding",
                          32'(rsp.cursor_col), 32'd0);
        end else begin
          want = replies_q.pop_front();
          if (rsp.cell_char !== want.cell_char)
            report_mismatch("cell_char", 32'(rsp.cell_char), 32'(want.cell_char));
          if (rsp.cell_attr !== want.cell_attr)
            report_mismatch("cell_attr", 32'(rsp.cell_attr), 32'(want.cell_attr));
          if (rsp.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", 32'(rsp.cursor_col), 32'(want.cursor_col));
          if (rsp.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", 32'(rsp.cursor_row), 32'(want.cursor_row));
          if (rsp.scrolled !== want.scrolled)
            report_mismatch("scrolled", 32'(rsp.scrolled), 32'(want.scrolled));
        end
      end
      if (req.valid && req.ready)
        replies_q.push_back(predict_console_reply(req.cmd, req.char_code,
                                                  req.read_row, req.read_col));
    end
    replies_owed = replies_q.size();
  end

endmodule

// File: bench/text_console_char_engine_top_tb.sv
// Testbench top for the text console character engine: stimulus, flow control and verdict.
module text_console_char_engine_top_tb;
  import tcce_pkg::*;

  localparam int          COLUMNS       = 80;
  localparam int          ROWS          = 25;
  // A scroll and the clearing pass after reset each sweep the whole store, so the limit
  // is set well above a run in which a large share of the beats scroll.
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int          PHASE_ITEMS   = 70;
  // Cycles allowed after the last response beat before the block is treated as idle.
  localparam int          SETTLE_CYCLES = 16;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_data;
  int          mismatch_count;
  int          replies_owed;
  int unsigned cycle_count = 0;
  // While quiet_left is non-zero neither side starts a new gap or stall, giving stretches at full rate.
  int          quiet_left  = 0;
  int          stall_left  = 0;
  // Counts beats that do something; ignored bytes are not counted towards a phase.
  int          useful_items = 0;
  logic [7:0]  attr_plan [5];

  tcce_req_if request_bus ();
  tcce_rsp_if response_bus ();

  text_console_char_engine_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .request  (request_bus),
    .response (response_bus)
  );

  tcce_console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .req            (request_bus),
    .rsp            (response_bus),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs or stops handshaking.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_char_engine_top_tb NOT OK");
      $finish;
    end
  end

  // Gap lengths: mostly from the shortest band, sometimes from the middle band, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 20);
    else return $urandom_range(21, 150);
  endfunction

  // The receiver stalls the response channel at random. Quiet stretches are started
  // here as well, and the sender honours them too.
  always @(negedge clk) begin
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 399) == 0) quiet_left = $urandom_range(100, 400);
    if (stall_left > 0) begin
      stall_left--;
      response_bus.ready <= 1'b0;
    end else begin
      response_bus.ready <= 1'b1;
      if (quiet_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Presents one command beat and returns once it has been accepted. Any idle gap comes
  // first, with valid low and the payload scrambled, so that valid is never dropped and
  // raised in the same step.
  task automatic send_command(input logic cmd, input logic [7:0] code,
                              input logic [4:0] row, input logic [6:0] col);
    int gap;
    gap = (quiet_left == 0 && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      request_bus.valid     <= 1'b0;
      request_bus.cmd       <= 1'($urandom_range(0, 1));
      request_bus.char_code <= 8'($urandom());
      request_bus.read_row  <= 5'($urandom());
      request_bus.read_col  <= 7'($urandom());
      repeat (gap) @(negedge clk);
    end
    request_bus.valid     <= 1'b1;
    request_bus.cmd       <= cmd;
    request_bus.char_code <= code;
    request_bus.read_row  <= row;
    request_bus.read_col  <= col;
    do @(posedge clk); while (request_bus.ready !== 1'b1);
  endtask

  task automatic put_byte(input logic [7:0] code);
    send_command(CMD_PUT, code, 5'($urandom()), 7'($urandom()));
  endtask

  task automatic read_cell(input logic [4:0] row, input logic [6:0] col);
    send_command(CMD_READ, 8'($urandom()), row, col);
  endtask

  // Holds the request channel idle until every predicted beat has come back, then lets
  // the block settle. Register writes are only made after this.
  task automatic drain_responses();
    @(negedge clk);
    request_bus.valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random console traffic shaped like real text: lines of printable characters with
  // the odd tab or backspace, runs of line feeds that push the screen into scrolling,
  // bursts of cell reads, and a little noise of bytes the engine ignores.
  task automatic run_text_traffic(input int quota);
    int         target;
    int         kind;
    int         len;
    logic [7:0] b;
    logic [4:0] row;
    logic [6:0] col;
    target = useful_items + quota;
    while (useful_items < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // Most lines are short; one in ten is long and can wrap one or more times.
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 20);
        for (int n = 0; n < len; n++) begin
          case ($urandom_range(0, 19))
            0:       put_byte(CH_TAB);
            1:       put_byte(CH_BACKSPACE);
            default: put_byte(8'($urandom_range(32'h20, 32'h7F)));
          endcase
          useful_items++;
        end
        if ($urandom_range(0, 1)) begin
          put_byte(CH_CR);
          useful_items++;
        end
        put_byte(CH_LF);
        useful_items++;
      end else if (kind < 60) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          put_byte(CH_LF);
          useful_items++;
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          row = 5'($urandom_range(0, ROWS - 1));
          col = 7'($urandom_range(0, COLUMNS - 1));
          // One read in eight goes outside the screen, on the row, the column or both.
          if ($urandom_range(0, 7) == 0) begin
            row = 5'($urandom());
            col = 7'($urandom());
            if (row < ROWS && col < COLUMNS) begin
              if ($urandom_range(0, 1)) row = 5'($urandom_range(ROWS, 31));
              else col = 7'($urandom_range(COLUMNS, 127));
            end
          end
          read_cell(row, col);
          useful_items++;
        end
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if ($urandom_range(0, 1)) begin
            do b = 8'($urandom_range(0, 31));
            while (b == CH_BACKSPACE || b == CH_TAB || b == CH_LF || b == CH_CR);
          end else begin
            b = 8'($urandom_range(128, 255));
          end
          put_byte(b);
        end
        // Occasionally the sender waits for every outstanding beat before going on.
        if ($urandom_range(0, 9) == 0) drain_responses();
      end
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_data              = '0;
    request_bus.valid     = 1'b0;
    request_bus.cmd       = CMD_PUT;
    request_bus.char_code = '0;
    request_bus.read_row  = '0;
    request_bus.read_col  = '0;
    response_bus.ready    = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part, run with the attribute left at its reset value. The screen is
    // cleared after reset, so the first reads must come back as zero.
    read_cell(5'd0, 7'd0);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'd31, 7'd127);
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd0, 7'(COLUMNS));
    // Backspace in the first column leaves the cursor alone.
    put_byte(CH_BACKSPACE);
    // The edges of the printable range, then bytes that must be ignored.
    put_byte(CH_SPACE);
    put_byte(8'h7F);
    put_byte(8'h00);
    put_byte(8'h1F);
    put_byte(8'h80);
    put_byte(8'hFF);
    // Tab from column two and from a tab stop, then backspace, return and line feed.
    put_byte(CH_TAB);
    put_byte(CH_TAB);
    put_byte(CH_BACKSPACE);
    put_byte(CH_CR);
    put_byte(CH_LF);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
    drain_responses();

    // Random phases, each under its own attribute, the extremes among them. The block
    // is idle at every write since the previous phase has fully drained.
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'($urandom());
    attr_plan[3] = 8'($urandom());
    attr_plan[4] = ATTR_RESET;
    for (int p = 0; p < 5; p++) begin
      write_attribute(attr_plan[p]);
      run_text_traffic(PHASE_ITEMS);
      drain_responses();
    end

    if (mismatch_count == 0 && replies_owed == 0)
      $display("text_console_char_engine_top_tb OK");
    else
      $display("text_console_char_engine_top_tb NOT OK");
    $finish;
  end

endmodule
